@@ design/absrv_pkg.sv @@
// ----------------------------------------------------------------------------
// absrv_pkg
// Shared codes, constants and CRC-32 helpers for the A/B slot record
// verifier.
// ----------------------------------------------------------------------------
`default_nettype none

package absrv_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 65535;
  localparam int unsigned LEN_W           = 16;
  localparam int unsigned POS_W           = 17;
  localparam int unsigned HDR_BYTES       = 24;
  localparam int unsigned CRC_HDR_BYTES   = 12;
  localparam int unsigned HDR_CAP_BYTES   = 16;
  localparam logic [LEN_W-1:0] LEN_RESET  = 16'd256;

  localparam logic [31:0] REC_MAGIC = 32'h4346_4742;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL1  = 32'hFFFF_FFFF;
  localparam logic [31:0] GEN_HALF  = 32'h8000_0000;

  typedef enum logic {
    FUNC_SCAN = 1'b0,
    FUNC_SAVE = 1'b1
  } func_e;

  typedef enum logic {
    KIND_SCAN = 1'b0,
    KIND_SAVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_SIZE    = 2'd2,
    ST_CRC     = 2'd3
  } status_e;

  // One result beat.
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [31:0] record_generation;
    logic [31:0] record_crc;
    logic        target_slot;
    logic        adopted;
    logic        matches_current;
    logic        record_present;
    logic [31:0] current_gen;
  } result_t;

  // Eight byte tables: entry i of table k is byte i followed by k zero bytes.
  typedef logic [7:0][255:0][31:0] crc_tabs_t;

  // Elaboration only: advance the CRC over a number of zero bits.
  function automatic logic [31:0] crc_shift_bits(logic [31:0] c, int unsigned nbits);
    logic [31:0] r;
    r = c;
    for (int unsigned k = 0; k < nbits; k++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'h0);
    end
    return r;
  endfunction

  function automatic crc_tabs_t crc_build_tabs();
    crc_tabs_t t;
    for (int unsigned k = 0; k < 8; k++) begin
      for (int unsigned i = 0; i < 256; i++) begin
        t[k][i] = crc_shift_bits(32'(i), 8 * (k + 1));
      end
    end
    return t;
  endfunction

  localparam crc_tabs_t CRC_TABS = crc_build_tabs();

  // CRC state after magic, then shifted over the gen and size words (zero part).
  localparam logic [31:0] CRC_AFTER_MAGIC = crc_shift_bits(CRC_ALL1 ^ REC_MAGIC, 32);
  localparam logic [31:0] CRC_SEED_BASE   = crc_shift_bits(CRC_AFTER_MAGIC, 64);

  // Fold one byte: eight bit steps.
  function automatic logic [31:0] crc_fold_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'h0);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/ab_slot_record_verifier_top.sv @@
// ----------------------------------------------------------------------------
// ab_slot_record_verifier_top
// Scans and prepares two-slot (A/B) configuration records one byte per beat.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless stalled; the result is registered:
// each accepted byte is folded into the CRC, the header capture and the
// record bookkeeping in the cycle it arrives, and the last byte of a stream
// loads one result beat. The longest path is the start of a save stream,
// where the header seed (six constant-table reads, XOR-combined) feeds the
// byte-wide CRC fold. The input stalls only while a result waits and the
// downstream side stalls. In scan mode (func 0) a slot arrives as 24
// little-endian header bytes (magic, generation, size, crc, two reserved
// words) followed by payload_length payload bytes; the verdict reports the
// first failing check (bad magic or zero generation, size mismatch, CRC
// mismatch), and a valid slot whose generation is newer under serial-number
// comparison (or any valid slot if none is held) becomes current. In save
// mode (func 1) payload_length bytes arrive; the block picks the next
// generation (skipping zero), the target slot (its bit 0) and the CRC over
// magic, generation, size and payload, then makes that generation current.
// A byte of another mode, or a scan byte from the other slot, restarts the
// stream with that byte. Writing payload_length restarts the stream; while
// it is zero or above MAX_PAYLOAD all bytes are dropped. Write the register
// only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ab_slot_record_verifier_top #(
  parameter int unsigned MAX_PAYLOAD = absrv_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration write channel
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [absrv_pkg::LEN_W-1:0]  cfg_data_i,
  // input beat
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire                          func_i,
  input  wire                          slot_i,
  input  wire  [7:0]                   data_byte_i,
  // result beat
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         kind_o,
  output logic [1:0]                   status_o,
  output logic [31:0]                  record_generation_o,
  output logic [31:0]                  record_crc_o,
  output logic                         target_slot_o,
  output logic                         adopted_o,
  output logic                         matches_current_o,
  output logic                         record_present_o,
  output logic [31:0]                  current_gen_o
);

  import absrv_pkg::*;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0] len_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      crc_q, crc_d;
  logic [31:0]      cur_gen_q, cur_gen_d;
  logic             has_rec_q, has_rec_d;
  func_e            sfunc_q;
  logic             sslot_q;
  logic [3:0][31:0] hdr_q;
  logic [31:0]      save_gen_q, save_gen_d;

  logic             out_valid_q;
  result_t          res_q, res_d;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic in_acc;
  logic cfg_acc;
  logic len_ok;
  logic done;
  logic step;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  // Hold the input only while a result waits and downstream stalls.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign len_ok      = (len_q != '0) && (32'(len_q) <= MAX_PAYLOAD);
  assign step        = in_acc & len_ok;

  // --------------------------------------------------------------------------
  // Per-byte datapath
  // --------------------------------------------------------------------------
  func_e            func_in;
  logic             restart;
  logic [POS_W-1:0] pos_eff;
  logic [POS_W-1:0] pos_inc;
  logic             start;
  logic [31:0]      crc_eff;
  logic [31:0]      crc_fold;
  logic [31:0]      fin_crc;
  logic [31:0]      gen_next;
  logic [31:0]      save_seed;
  logic [31:0]      gen_sel;
  logic [31:0]      gen_diff;
  logic             gen_newer;
  logic             adopt;
  status_e          scan_status;
  logic [31:0]      scan_cur;

  always_comb begin
    func_in = func_e'(func_i);
    // A mode change or a scan from the other slot restarts the stream.
    restart = (pos_q != '0) &&
              ((func_in != sfunc_q) || ((func_in == FUNC_SCAN) && (slot_i != sslot_q)));
    pos_eff = restart ? '0 : pos_q;
    pos_inc = pos_eff + POS_W'(1);
    start   = (pos_eff == '0);
    crc_eff = start ? CRC_ALL1 : crc_q;

    // Next save generation, never zero.
    gen_next = cur_gen_q + 32'd1;
    if (gen_next == '0) begin
      gen_next = 32'd1;
    end

    // Save seed: magic, generation and size folded in via zero-shift tables.
    save_seed = CRC_SEED_BASE
              ^ CRC_TABS[7][gen_next[7:0]]   ^ CRC_TABS[6][gen_next[15:8]]
              ^ CRC_TABS[5][gen_next[23:16]] ^ CRC_TABS[4][gen_next[31:24]]
              ^ CRC_TABS[3][len_q[7:0]]      ^ CRC_TABS[2][len_q[15:8]];

    gen_sel  = 32'h0;
    crc_fold = crc_eff;
    done     = 1'b0;
    if (func_in == FUNC_SAVE) begin
      gen_sel  = start ? gen_next : save_gen_q;
      crc_fold = crc_fold_byte(start ? save_seed : crc_q, data_byte_i);
      done     = (pos_inc == POS_W'(len_q));
    end else begin
      gen_sel = hdr_q[1];
      if ((pos_eff < POS_W'(CRC_HDR_BYTES)) || (pos_eff >= POS_W'(HDR_BYTES))) begin
        crc_fold = crc_fold_byte(crc_eff, data_byte_i);
      end
      done = (pos_inc == (POS_W'(HDR_BYTES) + POS_W'(len_q)));
    end
    fin_crc = crc_fold ^ CRC_ALL1;

    // Scan verdict; the final byte is always payload, so the header is complete.
    if ((hdr_q[0] != REC_MAGIC) || (hdr_q[1] == '0)) begin
      scan_status = ST_BAD_HDR;
    end else if (hdr_q[2] != 32'(len_q)) begin
      scan_status = ST_SIZE;
    end else if (fin_crc != hdr_q[3]) begin
      scan_status = ST_CRC;
    end else begin
      scan_status = ST_OK;
    end

    // Serial-number comparison against the current generation.
    gen_diff  = hdr_q[1] - cur_gen_q;
    gen_newer = (hdr_q[1] != '0) && (gen_diff != '0) && (gen_diff < GEN_HALF);
    adopt     = (scan_status == ST_OK) && (!has_rec_q || gen_newer);
    scan_cur  = adopt ? hdr_q[1] : cur_gen_q;
  end

  // Next state and result beat.
  always_comb begin
    pos_d      = pos_q;
    crc_d      = crc_q;
    cur_gen_d  = cur_gen_q;
    has_rec_d  = has_rec_q;
    save_gen_d = save_gen_q;
    res_d      = res_q;

    if (cfg_acc) begin
      pos_d = '0;
      crc_d = CRC_ALL1;
    end else if (step) begin
      pos_d = done ? '0 : pos_inc;
      crc_d = done ? CRC_ALL1 : crc_fold;
      if ((func_in == FUNC_SAVE) && start) begin
        save_gen_d = gen_next;
      end
      if (done) begin
        if (func_in == FUNC_SAVE) begin
          cur_gen_d = gen_sel;
          has_rec_d = 1'b1;
          res_d.kind              = KIND_SAVE;
          res_d.status            = ST_OK;
          res_d.record_generation = gen_sel;
          res_d.record_crc        = fin_crc;
          res_d.target_slot       = gen_sel[0];
          res_d.adopted           = 1'b1;
          res_d.matches_current   = 1'b1;
          res_d.record_present    = 1'b1;
          res_d.current_gen       = gen_sel;
        end else begin
          cur_gen_d = scan_cur;
          has_rec_d = has_rec_q | adopt;
          res_d.kind              = KIND_SCAN;
          res_d.status            = scan_status;
          res_d.record_generation = gen_sel;
          res_d.record_crc        = fin_crc;
          res_d.target_slot       = slot_i;
          res_d.adopted           = adopt;
          res_d.matches_current   = (scan_status == ST_OK) && (gen_sel == scan_cur);
          res_d.record_present    = has_rec_q | adopt;
          res_d.current_gen       = scan_cur;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= LEN_RESET;
      pos_q       <= '0;
      crc_q       <= CRC_ALL1;
      cur_gen_q   <= '0;
      has_rec_q   <= 1'b0;
      sfunc_q     <= FUNC_SCAN;
      sslot_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_acc) begin
        len_q <= cfg_data_i;
      end
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      cur_gen_q <= cur_gen_d;
      has_rec_q <= has_rec_d;
      if (!cfg_acc && step && start) begin
        sfunc_q <= func_in;
        sslot_q <= slot_i;
      end
      if (!cfg_acc && step && done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: header capture, save generation, result beat.
  always_ff @(posedge clk_i) begin
    if (!cfg_acc && step && (func_in == FUNC_SCAN) && (pos_eff < POS_W'(HDR_CAP_BYTES))) begin
      hdr_q[pos_eff[3:2]][8*pos_eff[1:0] +: 8] <= data_byte_i;
    end
    save_gen_q <= save_gen_d;
    res_q      <= res_d;
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_valid_o         = out_valid_q;
  assign kind_o              = res_q.kind;
  assign status_o            = res_q.status;
  assign record_generation_o = res_q.record_generation;
  assign record_crc_o        = res_q.record_crc;
  assign target_slot_o       = res_q.target_slot;
  assign adopted_o           = res_q.adopted;
  assign matches_current_o   = res_q.matches_current;
  assign record_present_o    = res_q.record_present;
  assign current_gen_o       = res_q.current_gen;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_save_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_SAVE)) |->
      ((status_o == ST_OK) && adopted_o && matches_current_o && record_present_o))
    else $error("save beat not reported as adopted");

  a_adopt_current : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && adopted_o) |->
      ((current_gen_o == record_generation_o) && record_present_o))
    else $error("adopted record is not current");

  a_match_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && matches_current_o) |-> (status_o == ST_OK))
    else $error("match flagged on an invalid record");

  a_stall_reason : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

endmodule

`default_nettype wire
